// ===== design/assert_macros.svh =====
// Assertion macros used by the sensor master top design file.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define HTS_ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the following cycle.
`define HTS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hts_pkg.sv =====
// Shared types and constants of the two-wire humidity sensor master.
// No dependencies.
package hts_pkg;

  localparam int RAW_W   = 16;
  localparam int VALUE_W = 17;

  localparam logic KIND_HUM  = 1'b0;
  localparam logic KIND_TEMP = 1'b1;

  localparam logic [7:0] CMD_HUMIDITY    = 8'b00000101;
  localparam logic [7:0] CMD_TEMPERATURE = 8'b00000011;

  localparam logic [7:0]  HUM_KNEE      = 8'd107;
  localparam logic [7:0]  HUM_SLOPE_LO  = 8'd143;
  localparam logic [7:0]  HUM_SLOPE_HI  = 8'd111;
  localparam logic [15:0] HUM_OFFSET_LO = 16'd512;
  localparam logic [15:0] HUM_OFFSET_HI = 16'd2893;
  localparam logic [15:0] HUM_CAP       = 16'd25600;
  localparam logic signed [VALUE_W-1:0] TEMP_OFFSET = 17'sd3963;

  typedef logic [RAW_W-1:0]          raw_t;
  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

// ===== design/humidity_temp_sensor_bus_master_top.sv =====
// Two-wire humidity and temperature sensor master, one pin action per request.
// An accepted request's result is registered and appears in the output register next cycle.
// Throughput: one request per cycle while out_tready is high; the output register frees as it is taken.
// Reset (synchronous, active low) returns the sequencer to idle and the control and
// configuration registers to their defaults. Depends on hts_pkg, hts_conv and assert_macros.svh.
`include "assert_macros.svh"

module humidity_temp_sensor_bus_master_top #(
  parameter int RAW_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // sda_in [0], zero padding above.
  input  logic [1:0]  in_tuser,   // op [1:0].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // sck, sda_oe, sda_out, busy_res, timed_out, raw_value, value.
  output logic        out_tlast,  // done_res.
  output logic        out_tuser,  // kind.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_SCKH1    = 5'd1;
  localparam logic [4:0] PH_SDAL     = 5'd2;
  localparam logic [4:0] PH_SCKL1    = 5'd3;
  localparam logic [4:0] PH_SCKH2    = 5'd4;
  localparam logic [4:0] PH_SDAH     = 5'd5;
  localparam logic [4:0] PH_SCKL2    = 5'd6;
  localparam logic [4:0] PH_CMD_LOW  = 5'd7;
  localparam logic [4:0] PH_CMD_HIGH = 5'd8;
  localparam logic [4:0] PH_ACK_REL  = 5'd9;
  localparam logic [4:0] PH_ACK_WAIT = 5'd10;
  localparam logic [4:0] PH_ACK_CLK  = 5'd11;
  localparam logic [4:0] PH_ACK_CLKL = 5'd12;
  localparam logic [4:0] PH_REL_WAIT = 5'd13;
  localparam logic [4:0] PH_POLL     = 5'd14;
  localparam logic [4:0] PH_RD_LOW   = 5'd15;
  localparam logic [4:0] PH_RD_HIGH  = 5'd16;
  localparam logic [4:0] PH_DONE     = 5'd17;

  localparam logic [1:0] OP_HUM  = 2'd1;
  localparam logic [1:0] OP_TEMP = 2'd2;

  localparam logic       REG_POLL_INTERVAL = 1'b0;
  localparam logic       REG_MAX_POLLS     = 1'b1;

  localparam logic [4:0] RAW_LIMIT = 5'(RAW_BITS);

  logic [15:0] poll_interval_r;
  logic [7:0]  max_polls_r;
  logic [4:0]  phase_r, phase_nxt;
  logic [4:0]  bit_count_r, bit_count_nxt;
  hts_pkg::raw_t shift_reg_r, shift_reg_nxt;
  logic [7:0]  poll_count_r, poll_count_nxt;
  logic [15:0] interval_count_r, interval_count_nxt;
  logic        measure_kind_r, measure_kind_nxt;
  logic        timeout_flag_r, timeout_flag_nxt;

  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic        out_last_r;
  logic        out_user_r;

  logic        accept;
  logic        cfg_write;
  logic [1:0]  op;
  logic        sda;
  logic [7:0]  cmd;
  logic        cmd_bit;
  logic        sck, oe, dout, done;
  logic [7:0]  lim;
  logic [7:0]  poll_inc;
  hts_pkg::value_t value;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign op         = in_tuser;
  assign sda        = in_tdata[0];
  assign cmd        = (measure_kind_r == hts_pkg::KIND_TEMP) ? hts_pkg::CMD_TEMPERATURE
                                                              : hts_pkg::CMD_HUMIDITY;
  assign cmd_bit    = cmd[3'd7 - bit_count_r[2:0]];
  assign lim        = (max_polls_r == 8'd0) ? 8'd1 : max_polls_r;
  assign poll_inc   = poll_count_r + 8'd1;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_POLLS) ? {24'd0, max_polls_r}
                                                      : {16'd0, poll_interval_r};

  always_comb begin
    phase_nxt          = phase_r;
    bit_count_nxt      = bit_count_r;
    shift_reg_nxt      = shift_reg_r;
    poll_count_nxt     = poll_count_r;
    interval_count_nxt = interval_count_r;
    measure_kind_nxt   = measure_kind_r;
    timeout_flag_nxt   = timeout_flag_r;
    sck  = 1'b0;
    oe   = 1'b1;
    dout = 1'b0;
    done = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        oe = 1'b0;
        if (op == OP_HUM || op == OP_TEMP) begin
          measure_kind_nxt   = (op == OP_TEMP) ? hts_pkg::KIND_TEMP : hts_pkg::KIND_HUM;
          shift_reg_nxt      = '0;
          timeout_flag_nxt   = 1'b0;
          bit_count_nxt      = 5'd0;
          poll_count_nxt     = 8'd0;
          interval_count_nxt = 16'd0;
          oe   = 1'b1;
          dout = 1'b1;
          phase_nxt = PH_SCKH1;
        end
      end
      PH_SCKH1: begin
        sck = 1'b1; dout = 1'b1; phase_nxt = PH_SDAL;
      end
      PH_SDAL: begin
        sck = 1'b1; phase_nxt = PH_SCKL1;
      end
      PH_SCKL1: begin
        phase_nxt = PH_SCKH2;
      end
      PH_SCKH2: begin
        sck = 1'b1; phase_nxt = PH_SDAH;
      end
      PH_SDAH: begin
        sck = 1'b1; dout = 1'b1; phase_nxt = PH_SCKL2;
      end
      PH_SCKL2: begin
        dout = 1'b1; bit_count_nxt = 5'd0; phase_nxt = PH_CMD_LOW;
      end
      PH_CMD_LOW: begin
        dout = cmd_bit; phase_nxt = PH_CMD_HIGH;
      end
      PH_CMD_HIGH: begin
        sck  = 1'b1;
        dout = cmd_bit;
        bit_count_nxt = bit_count_r + 5'd1;
        phase_nxt = (bit_count_nxt >= 5'd8) ? PH_ACK_REL : PH_CMD_LOW;
      end
      PH_ACK_REL: begin
        oe = 1'b0; phase_nxt = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        oe = 1'b0;
        if (!sda) begin
          phase_nxt = PH_ACK_CLK;
        end
      end
      PH_ACK_CLK: begin
        oe = 1'b0; sck = 1'b1; phase_nxt = PH_ACK_CLKL;
      end
      PH_ACK_CLKL: begin
        oe = 1'b0; phase_nxt = PH_REL_WAIT;
      end
      PH_REL_WAIT: begin
        oe = 1'b0;
        if (sda) begin
          poll_count_nxt     = 8'd0;
          interval_count_nxt = 16'd0;
          phase_nxt          = PH_POLL;
        end
      end
      PH_POLL: begin
        oe = 1'b0;
        if (interval_count_r != 16'd0) begin
          interval_count_nxt = interval_count_r - 16'd1;
        end else if (!sda) begin
          bit_count_nxt = 5'd0;
          phase_nxt     = PH_RD_LOW;
        end else begin
          poll_count_nxt = poll_inc;
          if (poll_inc >= lim) begin
            timeout_flag_nxt = 1'b1;
            bit_count_nxt    = 5'd0;
            phase_nxt        = PH_RD_LOW;
          end else begin
            interval_count_nxt = (poll_interval_r == 16'd0) ? 16'd0
                                                             : poll_interval_r - 16'd1;
          end
        end
      end
      PH_RD_LOW: begin
        oe = 1'b0; phase_nxt = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        oe  = 1'b0;
        sck = 1'b1;
        shift_reg_nxt = {shift_reg_r[hts_pkg::RAW_W-2:0], sda};
        bit_count_nxt = bit_count_r + 5'd1;
        phase_nxt = (bit_count_nxt >= RAW_LIMIT) ? PH_DONE : PH_RD_LOW;
      end
      PH_DONE: begin
        oe = 1'b0; done = 1'b1; phase_nxt = PH_IDLE;
      end
      default: begin
        oe = 1'b0; phase_nxt = PH_IDLE;
      end
    endcase
  end

  hts_conv u_conv (
    .raw   (shift_reg_nxt),
    .kind  (measure_kind_nxt),
    .value (value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r  <= 16'd10000;
      max_polls_r      <= 8'd255;
      phase_r          <= PH_IDLE;
      bit_count_r      <= 5'd0;
      shift_reg_r      <= '0;
      poll_count_r     <= 8'd0;
      interval_count_r <= 16'd0;
      measure_kind_r   <= hts_pkg::KIND_HUM;
      timeout_flag_r   <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_paddr[2] == REG_POLL_INTERVAL) begin
          poll_interval_r <= cfg_pwdata[15:0];
        end else begin
          max_polls_r <= cfg_pwdata[7:0];
        end
      end
      if (accept) begin
        phase_r          <= phase_nxt;
        bit_count_r      <= bit_count_nxt;
        shift_reg_r      <= shift_reg_nxt;
        poll_count_r     <= poll_count_nxt;
        interval_count_r <= interval_count_nxt;
        measure_kind_r   <= measure_kind_nxt;
        timeout_flag_r   <= timeout_flag_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {2'b00, value, shift_reg_nxt, timeout_flag_nxt,
                     (phase_nxt != PH_IDLE), oe && dout, oe, sck};
      out_last_r <= done;
      out_user_r <= measure_kind_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  `HTS_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_tvalid, "accepted request produced no result")
  `HTS_ASSERT_NEXT(a_done_follows_read, clk, rst_n, accept && phase_r == PH_DONE, out_tlast && !out_tdata[3], "done phase did not mark the result as final")
  `HTS_ASSERT_ALWAYS(a_read_count_bound, clk, rst_n, phase_r != PH_RD_HIGH || bit_count_r < RAW_LIMIT, "read bit count ran past the raw width")

endmodule

// ===== design/hts_conv.sv =====
// Conversion of a raw sensor reading into humidity percent or offset temperature.
// Depends on hts_pkg.
module hts_conv (
  input  hts_pkg::raw_t   raw,
  input  logic            kind,
  output hts_pkg::value_t value
);

  logic [7:0]  s;
  logic [15:0] prod_lo;
  logic [15:0] prod_hi;
  logic [15:0] sum_hi;
  logic [15:0] rh;
  hts_pkg::value_t temp;

  assign s       = raw[11:4];
  assign prod_lo = 16'(s) * 16'(hts_pkg::HUM_SLOPE_LO);
  assign prod_hi = 16'(s) * 16'(hts_pkg::HUM_SLOPE_HI);
  assign sum_hi  = prod_hi + hts_pkg::HUM_OFFSET_HI;
  assign temp    = $signed({1'b0, raw}) - hts_pkg::TEMP_OFFSET;

  always_comb begin
    if (s <= hts_pkg::HUM_KNEE) begin
      rh = (prod_lo < hts_pkg::HUM_OFFSET_LO) ? 16'd0 : prod_lo - hts_pkg::HUM_OFFSET_LO;
    end else begin
      rh = (sum_hi > hts_pkg::HUM_CAP) ? hts_pkg::HUM_CAP : sum_hi;
    end
  end

  assign value = (kind == hts_pkg::KIND_TEMP) ? temp : $signed({9'd0, rh[15:8]});

endmodule
